FILE: sv/mef_pkg.sv
package mef_pkg;

    localparam int MAX_NODES = 16;
    localparam int CAP_BITS  = 16;
    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int CNT_BITS  = NODE_BITS + 1;
    localparam int ADDR_BITS = 2 * NODE_BITS;
    localparam int RES_BITS  = CAP_BITS + 1;
    localparam int FLOW_BITS = 20;
    localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] ST_WRITE = 2'd0;
    localparam logic [1:0] ST_FLOW  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_SAME  = 2'd3;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_SINK       = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_INIT    = 12'b000000000010,
        S_POP     = 12'b000000000100,
        S_SCAN_RD = 12'b000000001000,
        S_SCAN_EV = 12'b000000010000,
        S_CHECK   = 12'b000000100000,
        S_BN_RD   = 12'b000001000000,
        S_BN_EV   = 12'b000010000000,
        S_BN_DONE = 12'b000100000000,
        S_AU_RD   = 12'b001000000000,
        S_AU_FW   = 12'b010000000000,
        S_AU_BW   = 12'b100000000000
    } state_t;

endpackage

FILE: sv/max_flow_edmonds_karp.sv
// Edmonds-Karp maximum flow over a 16x16 residual matrix held in one
// single-port-write, registered-read memory. Pulse start while busy is low;
// mode picks the operation. A capacity write or a residual read returns its
// result on the next cycle with done high, and a new item may start in that
// same cycle. A run whose source and sink differ and lie below the node count
// holds busy high while a small sequencer drives the one memory port: each
// breadth-first search scans every neighbor of each dequeued node with one
// memory read each, and each augmenting path is walked once to find the
// bottleneck and once more to update forward and backward entries. The run
// ends when a search fails to reach the sink or a path has a zero
// bottleneck; its result appears the cycle after that.
// Results cannot be stalled: done is high for exactly one cycle and the
// result ports are valid only then; status 3 answers a run whose source
// equals its sink. Reading an entry never written since reset returns an
// undefined value. Configuration writes are always ready and must only be
// issued while the block is idle.
module max_flow_edmonds_karp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [3:0]                     from_node,
    input  logic [3:0]                     to_node,
    input  logic [15:0]                    capacity,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [mef_pkg::FLOW_BITS-1:0]  flow_total,
    output logic [mef_pkg::RES_BITS-1:0]   residual_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [4:0]                     cfg_data
);
    import mef_pkg::*;

    // configuration
    logic [4:0]           node_count_reg;
    logic [NODE_BITS-1:0] source_reg;
    logic [NODE_BITS-1:0] sink_reg;

    // sequencer
    state_t state_reg, state_next;

    // residual matrix
    logic [RES_BITS-1:0] mem [MAX_NODES*MAX_NODES];
    logic [RES_BITS-1:0] mem_q;
    logic [ADDR_BITS-1:0] rd_addr, wr_addr;
    logic [RES_BITS-1:0]  wr_data;
    logic                 wr_en;

    // search state
    logic [NODE_BITS-1:0] queue [MAX_NODES];
    logic [NODE_BITS-1:0] parent [MAX_NODES];
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [CNT_BITS-1:0]  head_reg, head_next;
    logic [CNT_BITS-1:0]  tail_reg, tail_next;
    logic [CNT_BITS-1:0]  n_reg, n_next;
    logic [NODE_BITS-1:0] u_reg, u_next;
    logic [NODE_BITS-1:0] v_reg, v_next;
    logic [NODE_BITS-1:0] s_reg, s_next;
    logic [NODE_BITS-1:0] p_reg, p_next;
    logic [CNT_BITS-1:0]  steps_reg, steps_next;
    logic [RES_BITS-1:0]  bott_reg, bott_next;
    logic [FLOW_BITS-1:0] total_reg, total_next;
    logic                 q_we, p_we;
    logic [NODE_BITS-1:0] q_wa, q_wd, p_wa;

    // result registers
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [FLOW_BITS-1:0] flow_reg, flow_next;

    logic                 accept;
    logic [CNT_BITS-1:0]  n_clamp;
    logic [FLOW_BITS:0]   sum;
    logic                 walk_on;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // clamp node count into 2..MAX_NODES
    always_comb
    begin
        if (node_count_reg < 5'd2)
            n_clamp = CNT_BITS'(2);
        else if (CNT_BITS'(node_count_reg) > CNT_BITS'(MAX_NODES))
            n_clamp = CNT_BITS'(MAX_NODES);
        else
            n_clamp = CNT_BITS'(node_count_reg);
    end

    // the one accumulate path: add the bottleneck into the flow total
    assign sum     = {1'b0, total_reg} + (FLOW_BITS+1)'(bott_reg);
    assign walk_on = (s_reg != source_reg) && (steps_reg < n_reg);

    always_comb
    begin
        state_next   = state_reg;
        visited_next = visited_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        n_next       = n_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        s_next       = s_reg;
        p_next       = p_reg;
        steps_next   = steps_reg;
        bott_next    = bott_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        flow_next    = flow_reg;
        rd_addr      = {from_node, to_node};
        wr_en        = 1'b0;
        wr_addr      = {from_node, to_node};
        wr_data      = RES_BITS'(capacity);
        q_we         = 1'b0;
        q_wa         = tail_reg[NODE_BITS-1:0];
        q_wd         = v_reg;
        p_we         = 1'b0;
        p_wa         = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next  = 1'b1;
                    flow_next  = '0;
                    total_next = '0;
                    n_next     = n_clamp;
                    priority if (mode == MODE_WRITE)
                    begin
                        status_next = ST_WRITE;
                        wr_en       = 1'b1;
                    end
                    else if (mode == MODE_READ)
                        status_next = ST_READ;
                    else if (mode == MODE_RUN)
                    begin
                        if (source_reg == sink_reg)
                            status_next = ST_SAME;
                        else
                        begin
                            status_next = ST_FLOW;
                            // a run with an unused source or sink reports zero
                            if (CNT_BITS'(source_reg) < n_clamp &&
                                CNT_BITS'(sink_reg) < n_clamp)
                            begin
                                done_next  = 1'b0;
                                state_next = S_INIT;
                            end
                        end
                    end
                    else
                        status_next = ST_WRITE;
                end
            end
            S_INIT:
            begin
                visited_next = '0;
                visited_next[source_reg] = 1'b1;
                q_we       = 1'b1;
                q_wa       = '0;
                q_wd       = source_reg;
                head_next  = '0;
                tail_next  = CNT_BITS'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    u_next     = queue[head_reg[NODE_BITS-1:0]];
                    head_next  = head_reg + 1'b1;
                    v_next     = '0;
                    state_next = S_SCAN_RD;
                end
                else
                    state_next = S_CHECK;
            end
            S_SCAN_RD:
            begin
                rd_addr    = {u_reg, v_reg};
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (!visited_reg[v_reg] && mem_q != '0 && tail_reg < n_reg)
                begin
                    q_we    = 1'b1;
                    p_we    = 1'b1;
                    visited_next[v_reg] = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                if (CNT_BITS'(v_reg) == n_reg - 1'b1)
                    state_next = S_POP;
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_CHECK:
            begin
                if (visited_reg[sink_reg])
                begin
                    s_next     = sink_reg;
                    steps_next = '0;
                    bott_next  = '1;
                    state_next = S_BN_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    flow_next  = total_reg;
                    state_next = S_IDLE;
                end
            end
            S_BN_RD:
            begin
                if (walk_on)
                begin
                    p_next     = parent[s_reg];
                    rd_addr    = {parent[s_reg], s_reg};
                    state_next = S_BN_EV;
                end
                else
                    state_next = S_BN_DONE;
            end
            S_BN_EV:
            begin
                if (mem_q < bott_reg)
                    bott_next = mem_q;
                s_next     = p_reg;
                steps_next = steps_reg + 1'b1;
                state_next = S_BN_RD;
            end
            S_BN_DONE:
            begin
                if (bott_reg == '0)
                begin
                    done_next  = 1'b1;
                    flow_next  = total_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    total_next = sum[FLOW_BITS] ? FLOW_MAX : sum[FLOW_BITS-1:0];
                    s_next     = sink_reg;
                    steps_next = '0;
                    state_next = S_AU_RD;
                end
            end
            S_AU_RD:
            begin
                if (walk_on)
                begin
                    p_next     = parent[s_reg];
                    rd_addr    = {parent[s_reg], s_reg};
                    state_next = S_AU_FW;
                end
                else
                    state_next = S_INIT;
            end
            S_AU_FW:
            begin
                // drop the bottleneck from the forward entry, fetch the reverse
                wr_en      = 1'b1;
                wr_addr    = {p_reg, s_reg};
                wr_data    = mem_q - bott_reg;
                rd_addr    = {s_reg, p_reg};
                state_next = S_AU_BW;
            end
            S_AU_BW:
            begin
                wr_en      = 1'b1;
                wr_addr    = {s_reg, p_reg};
                wr_data    = mem_q + bott_reg;
                s_next     = p_reg;
                steps_next = steps_reg + 1'b1;
                state_next = S_AU_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        mem_q <= mem[rd_addr];
        if (q_we)
            queue[q_wa] <= q_wd;
        if (p_we)
            parent[p_wa] <= u_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 5'd16;
            source_reg     <= NODE_BITS'(0);
            sink_reg       <= NODE_BITS'(15);
            state_reg      <= S_IDLE;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            n_reg          <= CNT_BITS'(MAX_NODES);
            u_reg          <= '0;
            v_reg          <= '0;
            s_reg          <= '0;
            p_reg          <= '0;
            steps_reg      <= '0;
            bott_reg       <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
            status_reg     <= ST_WRITE;
            flow_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= cfg_data;
                    CFG_SOURCE:     source_reg     <= cfg_data[NODE_BITS-1:0];
                    CFG_SINK:       sink_reg       <= cfg_data[NODE_BITS-1:0];
                    default:        ;
                endcase
            end
            state_reg   <= state_next;
            visited_reg <= visited_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            n_reg       <= n_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            s_reg       <= s_next;
            p_reg       <= p_next;
            steps_reg   <= steps_next;
            bott_reg    <= bott_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            flow_reg    <= flow_next;
        end
    end

    // hold the read data on the result port only for a read transfer
    assign done           = done_reg;
    assign status         = status_reg;
    assign flow_total     = flow_reg;
    assign residual_value = (done_reg && status_reg == ST_READ) ? mem_q : '0;

    a_fail_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !visited_reg[sink_reg]) |=>
            (done && status == ST_FLOW && state_reg == S_IDLE))
        else $error("failed search did not report flow");

    // the pointers still hold the previous run's values while a search starts
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_INIT) |->
            (tail_reg <= n_reg && head_reg <= tail_reg))
        else $error("queue pointers out of range");

    a_bottleneck_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AU_FW) |-> (bott_reg <= mem_q && bott_reg != '0))
        else $error("forward residual below bottleneck");

    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

endmodule

FILE: dv/tb_max_flow_edmonds_karp.sv
`default_nettype none

module tb_max_flow_edmonds_karp;
    timeunit 1ns;
    timeprecision 1ps;
    import mef_pkg::*;

    localparam int QUIET_LIMIT = 5000000; // cycles with no transfer at all
    localparam int SETTLE      = 8;       // idle cycles before a register write

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_PAUSE} kind_t;

    typedef struct {
        kind_t       kind;
        logic [1:0]  op;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] cap;
        logic [1:0]  reg_idx;
        logic [4:0]  reg_val;
    } job_t;

    typedef struct {
        logic [1:0]           st;
        logic [FLOW_BITS-1:0] flow;
        logic [RES_BITS-1:0]  resid;
    } answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           mode;
    logic [3:0]           from_node;
    logic [3:0]           to_node;
    logic [15:0]          capacity;
    logic                 done;
    logic [1:0]           status;
    logic [FLOW_BITS-1:0] flow_total;
    logic [RES_BITS-1:0]  residual_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [4:0]           cfg_data;

    max_flow_edmonds_karp uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .from_node      (from_node),
        .to_node        (to_node),
        .capacity       (capacity),
        .done           (done),
        .status         (status),
        .flow_total     (flow_total),
        .residual_value (residual_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Shadow copy of the block: residual matrix plus the three registers.
    logic [RES_BITS-1:0] shadow_res [MAX_NODES*MAX_NODES];
    logic [4:0]          sh_nodes;
    logic [3:0]          sh_src;
    logic [3:0]          sh_snk;

    job_t    pending_jobs[$];
    answer_t expected_answers[$];
    int      errors;
    int      settle_cnt;
    int      quiet_cnt;
    int      burst_left;
    int      gap_left;
    logic    took;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Repeat breadth-first searches and augment each path by its bottleneck.
    function automatic logic [FLOW_BITS-1:0] flow_model(input int n);
        int                  q [MAX_NODES];
        int                  par [MAX_NODES];
        logic [15:0]         seen;
        int                  head;
        int                  tail;
        int                  u;
        int                  s;
        int                  steps;
        logic [RES_BITS-1:0] bn;
        longint              total;
        total = 0;
        while (1)
        begin
            head = 0;
            tail = 0;
            seen = '0;
            seen[sh_src] = 1'b1;
            q[tail++] = int'(sh_src);
            while (head < tail)
            begin
                u = q[head++];
                for (int v = 0; v < n; v++)
                begin
                    if (!seen[v] && shadow_res[u*MAX_NODES+v] != 0 && tail < n)
                    begin
                        q[tail++] = v;
                        seen[v] = 1'b1;
                        par[v] = u;
                    end
                end
            end
            if (!seen[sh_snk])
                break;
            bn = '1;
            s = int'(sh_snk);
            steps = 0;
            while (s != sh_src && steps < n)
            begin
                if (shadow_res[par[s]*MAX_NODES+s] < bn)
                    bn = shadow_res[par[s]*MAX_NODES+s];
                s = par[s];
                steps++;
            end
            if (bn == 0)
                break;
            total += bn;
            if (total > FLOW_MAX)
                total = FLOW_MAX;
            s = int'(sh_snk);
            steps = 0;
            while (s != sh_src && steps < n)
            begin
                shadow_res[par[s]*MAX_NODES+s] -= bn;
                shadow_res[s*MAX_NODES+par[s]] += bn;  // wraps at RES_BITS
                s = par[s];
                steps++;
            end
        end
        return FLOW_BITS'(total);
    endfunction

    function automatic answer_t predict_answer(input job_t j);
        answer_t a;
        int      n;
        a.st = ST_WRITE;
        a.flow = '0;
        a.resid = '0;
        n = (sh_nodes < 2) ? 2 : (sh_nodes > MAX_NODES) ? MAX_NODES : int'(sh_nodes);
        case (j.op)
            MODE_WRITE:
                shadow_res[j.row*MAX_NODES+j.col] = {1'b0, j.cap};
            MODE_RUN:
            begin
                if (sh_src == sh_snk)
                    a.st = ST_SAME;
                else
                begin
                    a.st = ST_FLOW;
                    if (sh_src < n && sh_snk < n)
                        a.flow = flow_model(n);
                end
            end
            MODE_READ:
            begin
                a.st = ST_READ;
                a.resid = shadow_res[j.row*MAX_NODES+j.col];
            end
            default: ;
        endcase
        return a;
    endfunction

    // Sample at the rising edge: item and register transfers, results, watchdog.
    always @(posedge clk)
    begin
        answer_t a;
        logic    moved;
        moved = 1'b0;
        if (rst_n)
        begin
            took <= start && !busy;
            if (start && !busy)
            begin
                expected_answers = {expected_answers, predict_answer(pending_jobs[0])};
                void'(pending_jobs.pop_front());
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT: sh_nodes = cfg_data;
                    CFG_SOURCE:     sh_src = cfg_data[3:0];
                    CFG_SINK:       sh_snk = cfg_data[3:0];
                    default: ;
                endcase
                void'(pending_jobs.pop_front());
                moved = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (expected_answers.size() == 0)
                begin
                    $error("result with nothing expected: status %0d", status);
                    errors++;
                end
                else
                begin
                    a = expected_answers.pop_front();
                    if (status !== a.st)
                    begin
                        $error("status: expected %0d, got %0d", a.st, status);
                        errors++;
                    end
                    if (flow_total !== a.flow)
                    begin
                        $error("flow_total: expected %0d, got %0d", a.flow, flow_total);
                        errors++;
                    end
                    if (residual_value !== a.resid)
                    begin
                        $error("residual_value: expected %0d, got %0d",
                               a.resid, residual_value);
                        errors++;
                    end
                end
            end
            quiet_cnt <= moved ? 0 : quiet_cnt + 1;
            settle_cnt <= (expected_answers.size() == 0 && !busy && !done)
                          ? settle_cnt + 1 : 0;
            if (quiet_cnt > QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Drive at the falling edge: bursts of items, random gaps, idle-only writes.
    always @(negedge clk)
    begin
        logic       nx_start;
        logic       nx_cfg;
        job_t       j;
        nx_start = 1'b0;
        nx_cfg = 1'b0;
        if (rst_n && pending_jobs.size() != 0)
        begin
            j = pending_jobs[0];
            if (j.kind == K_ITEM)
            begin
                if (start && !took)
                    nx_start = 1'b1;         // hold until the block takes it
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    nx_start = 1'b1;
                    mode <= j.op;
                    from_node <= j.row;
                    to_node <= j.col;
                    capacity <= j.cap;
                    if (--burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            else if (settle_cnt >= SETTLE && !cfg_valid)
            begin
                if (j.kind == K_CFG)
                begin
                    nx_cfg = 1'b1;
                    cfg_index <= j.reg_idx;
                    cfg_data <= j.reg_val;
                end
                else
                    void'(pending_jobs.pop_front());  // drained: drop the pause
            end
        end
        start <= nx_start;
        cfg_valid <= nx_cfg;
    end

    task automatic add_item(input logic [1:0] op, input int r, input int c, input int cp);
        job_t j;
        j.kind = K_ITEM;
        j.op = op;
        j.row = 4'(r);
        j.col = 4'(c);
        j.cap = 16'(cp);
        j.reg_idx = '0;
        j.reg_val = '0;
        pending_jobs = {pending_jobs, j};
    endtask

    task automatic add_cfg(input logic [1:0] idx, input int val);
        job_t j;
        j.kind = K_CFG;
        j.op = MODE_WRITE;
        j.row = '0;
        j.col = '0;
        j.cap = '0;
        j.reg_idx = idx;
        j.reg_val = 5'(val);
        pending_jobs = {pending_jobs, j};
    endtask

    task automatic add_pause();
        job_t j;
        j.kind = K_PAUSE;
        j.op = MODE_WRITE;
        j.row = '0;
        j.col = '0;
        j.cap = '0;
        j.reg_idx = '0;
        j.reg_val = '0;
        pending_jobs = {pending_jobs, j};
    endtask

    function automatic int random_cap();
        case ($urandom_range(0, 5))
            0, 1: return 0;
            2:    return 16'hFFFF;
            3:    return $urandom_range(1, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial
    begin
        int count;
        int n;
        errors = 0;
        settle_cnt = 0;
        quiet_cnt = 0;
        burst_left = 4;
        gap_left = 0;
        took = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_WRITE;
        from_node = '0;
        to_node = '0;
        capacity = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        sh_nodes = 5'd16;
        sh_src = 4'd0;
        sh_snk = 4'd15;
        foreach (shadow_res[i])
            shadow_res[i] = '0;

        // Load every entry once so no search or read touches an unwritten one.
        for (int r = 0; r < MAX_NODES; r++)
            for (int c = 0; c < MAX_NODES; c++)
                add_item(MODE_WRITE, r, c, 0);

        // Directed: field extremes, unused mode, count clamping, bad nodes.
        add_item(MODE_WRITE, 15, 0, 16'hFFFF);
        add_item(MODE_READ, 15, 0, 0);
        add_item(MODE_READ, 0, 15, 16'hFFFF);
        add_item(2'd3, 15, 15, 16'hFFFF);
        add_item(MODE_WRITE, 0, 1, 7);
        add_item(MODE_WRITE, 1, 15, 5);
        add_item(MODE_RUN, 0, 0, 0);
        add_item(MODE_READ, 1, 0, 0);
        add_cfg(CFG_NODE_COUNT, 0);            // acts as two nodes: sink unused
        add_item(MODE_RUN, 0, 0, 0);
        add_cfg(CFG_SINK, 1);
        add_item(MODE_RUN, 0, 0, 0);
        add_cfg(CFG_NODE_COUNT, 31);           // acts as sixteen nodes
        add_cfg(CFG_SOURCE, 1);                // source equals sink
        add_item(MODE_RUN, 0, 0, 0);

        // Saturating flow: push one full run backward, then run forward over
        // the doubled residuals.
        add_cfg(CFG_SOURCE, 15);
        add_cfg(CFG_SINK, 0);
        for (int v = 1; v < 15; v++)
        begin
            add_item(MODE_WRITE, 15, v, 16'hFFFF);
            add_item(MODE_WRITE, v, 0, 16'hFFFF);
            add_item(MODE_WRITE, 0, v, 16'hFFFF);
            add_item(MODE_WRITE, v, 15, 16'hFFFF);
        end
        add_item(MODE_WRITE, 15, 0, 16'hFFFF);
        add_item(MODE_WRITE, 0, 15, 16'hFFFF);
        add_item(MODE_RUN, 0, 0, 0);
        add_cfg(CFG_SOURCE, 0);
        add_cfg(CFG_SINK, 15);
        add_item(MODE_RUN, 0, 0, 0);
        add_item(MODE_READ, 15, 1, 0);
        add_pause();

        // Random phases: new registers, then well-formed graph loads with runs.
        count = 0;
        while (count < 1020)
        begin
            case ($urandom_range(0, 7))
                0:       n = 16;
                1:       n = $urandom_range(0, 1);
                2:       n = $urandom_range(17, 31);
                default: n = $urandom_range(2, 8);
            endcase
            add_cfg(CFG_NODE_COUNT, n);
            add_cfg(CFG_SOURCE, $urandom_range(0, 15));
            add_cfg(CFG_SINK, ($urandom_range(0, 9) == 0) ? pending_jobs[$].reg_val
                                                         : $urandom_range(0, 15));
            if (n < 2)
                n = 2;
            if (n > 16)
                n = 16;
            repeat ($urandom_range(20, 50))
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                        add_item(MODE_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 65535));
                    2, 3, 4:
                        add_item(MODE_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 65535));
                    5:
                        add_item(2'd3, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 65535));
                    6:
                        add_item(MODE_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                                 random_cap());
                    default:
                        add_item(MODE_WRITE, $urandom_range(0, n - 1),
                                 $urandom_range(0, n - 1), random_cap());
                endcase
                count++;
            end
            if ($urandom_range(0, 3) == 0)
                add_pause();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_jobs.size() == 0 && expected_answers.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
